// ===== design/per_tag_scalar_kalman_position_top_defines.svh =====
`ifndef PER_TAG_SCALAR_KALMAN_POSITION_TOP_DEFINES_SVH
`define PER_TAG_SCALAR_KALMAN_POSITION_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTKP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptkp: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PTKP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptkp: next-cycle check failed");

`endif

// ===== design/ptkp_pkg.sv =====
package ptkp_pkg;

  localparam int NUM_TAGS = 16;
  localparam int NumSlots = 3 * NUM_TAGS;
  localparam int AddrW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int TagIdxW  = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

  localparam int DivSteps = 17;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [31:0] VarReset = 32'h0001_0000;
  localparam logic [16:0] GainOne  = 17'h1_0000;

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgProcessNoise = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMeasureNoise = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCoordLimit   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgInitVariance = 8'd3;

  localparam logic [31:0] RstProcessNoise = 32'd655;
  localparam logic [31:0] RstMeasureNoise = 32'd6554;
  localparam logic [30:0] RstCoordLimit   = 31'd65536000;
  localparam logic [31:0] RstInitVariance = 32'd65536;

  // Commands
  localparam logic CmdMeasure = 1'b0;
  localparam logic CmdInit    = 1'b1;

  // Axis codes
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         tag;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic [31:0]        var_x;
    logic [31:0]        var_y;
    logic [31:0]        var_z;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        value;
  } cfg_item_t;

endpackage

// ===== design/ptkp_if.sv =====
interface ptkp_in_if;
  import ptkp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptkp_out_if;
  import ptkp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptkp_cfg_if;
  import ptkp_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ptkp_ram.sv =====
module ptkp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== design/per_tag_scalar_kalman_position_top.sv =====
// Per-tag scalar Kalman position filter. Each item is one command: init loads a tag's X, Y
// and Z estimates with the given coordinates and the variances with init_variance; measure
// runs one random-walk Kalman step per axis unless any coordinate magnitude exceeds
// coord_limit, in which case state holds and the stored values come back with accepted 0.
// The block takes one item at a time and drops ready while it works. For a measure item
// each axis runs one RAM read, a load step, a 17-step radix-2 gain division, two passes
// through one 18x33 multiplier and one write; the result is loaded into the output
// register at the same edge that ready returns, and the next item can be accepted once
// ready is back. An axis with zero P'+R skips the division. Estimates and variances sit
// in two 32-bit RAMs of 3*NUM_TAGS words with one read and one write port; a valid bit
// per tag stands in for reset, so no clearing pass is needed and an unwritten tag reads
// as estimate 0, variance 1.0. The result waits in an output register until taken; the
// next item may be accepted meanwhile.
`include "per_tag_scalar_kalman_position_top_defines.svh"

module per_tag_scalar_kalman_position_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptkp_cfg_if.sink     cfg_i,
  ptkp_in_if.sink      in_i,
  ptkp_out_if.source   out_o
);
  import ptkp_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StCheck, StInit, StRead, StLoad, StDiv, StMulGain, StMulVar, StWrite, StDone
  } state_e;

  function automatic logic [31:0] coord_mag(input logic signed [31:0] c);
    logic [31:0] raw;
    raw = c;
    return c[31] ? (~raw + 32'd1) : raw;
  endfunction

  state_e               state_q;
  in_item_t             item_q;
  logic [1:0]           axis_q;
  logic                 filter_q;
  logic                 acc_q;
  logic [16:0]          k_q;
  logic [33:0]          rem_q;
  logic [32:0]          den_q;
  logic [31:0]          p_q;
  logic [31:0]          x_q;
  logic signed [32:0]   diff_q;
  logic signed [50:0]   prod_q;
  logic [31:0]          est_new_q;
  logic [DivCntW-1:0]   cnt_q;
  logic [31:0]          res_est_q [3];
  logic [31:0]          res_var_q [3];
  out_item_t            out_q;
  logic                 out_valid_q;
  logic [NUM_TAGS-1:0]  row_valid_q;
  logic [31:0]          proc_noise_q;
  logic [31:0]          meas_noise_q;
  logic [30:0]          coord_limit_q;
  logic [31:0]          init_var_q;

  logic [TagIdxW-1:0]   tag_idx;
  logic                 tag_ok;
  logic [AddrW-1:0]     slot;
  logic signed [31:0]   coord_sel;
  logic                 in_range;
  logic                 row_ok;
  logic [31:0]          est_rdata;
  logic [31:0]          var_rdata;
  logic [31:0]          est_rd;
  logic [31:0]          var_rd;
  logic [32:0]          p_sum;
  logic [31:0]          p_new;
  logic [32:0]          den_new;
  logic signed [32:0]   diff_new;
  logic [33:0]          den_ext;
  logic                 div_ge;
  logic [33:0]          div_rem;
  logic signed [17:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [50:0]   mul_p;
  logic                 ram_we;
  logic [31:0]          est_wdata;
  logic [31:0]          var_wdata;
  logic                 last_axis;

  assign tag_idx   = TagIdxW'(item_q.tag);
  assign tag_ok    = 32'(item_q.tag) < 32'(NUM_TAGS);
  assign slot      = AddrW'({tag_idx, 1'b0}) + AddrW'(tag_idx) + AddrW'(axis_q);
  assign last_axis = (axis_q == AxisZ);

  always_comb begin
    case (axis_q)
      AxisX:   coord_sel = item_q.coord_x;
      AxisY:   coord_sel = item_q.coord_y;
      default: coord_sel = item_q.coord_z;
    endcase
  end

  assign in_range = (coord_mag(item_q.coord_x) <= {1'b0, coord_limit_q})
                 && (coord_mag(item_q.coord_y) <= {1'b0, coord_limit_q})
                 && (coord_mag(item_q.coord_z) <= {1'b0, coord_limit_q});

  // A tag never written reads as its reset values.
  assign row_ok = row_valid_q[tag_idx];
  assign est_rd = row_ok ? est_rdata : 32'd0;
  assign var_rd = row_ok ? var_rdata : VarReset;

  // P' saturates at all ones.
  assign p_sum    = {1'b0, var_rd} + {1'b0, proc_noise_q};
  assign p_new    = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
  assign den_new  = {1'b0, p_new} + {1'b0, meas_noise_q};
  assign diff_new = $signed({coord_sel[31], coord_sel}) - $signed({est_rd[31], est_rd});

  // One restoring division step per cycle.
  assign den_ext = {1'b0, den_q};
  assign div_ge  = rem_q >= den_ext;
  assign div_rem = div_ge ? (rem_q - den_ext) : rem_q;

  // Shared multiplier: K*(m-x), then (1-K)*P'.
  always_comb begin
    if (state_q == StMulGain) begin
      mul_a = $signed({1'b0, k_q});
      mul_b = diff_q;
    end else begin
      mul_a = $signed({1'b0, 17'(GainOne - k_q)});
      mul_b = $signed({1'b0, p_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  assign ram_we    = (state_q == StWrite) || (state_q == StInit);
  assign est_wdata = (state_q == StInit) ? coord_sel : est_new_q;
  assign var_wdata = (state_q == StInit) ? init_var_q : prod_q[47:16];

  ptkp_ram #(.WIDTH(32), .DEPTH(NumSlots)) u_est_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (est_wdata),
    .raddr_i (slot),
    .rdata_o (est_rdata)
  );

  ptkp_ram #(.WIDTH(32), .DEPTH(NumSlots)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (var_wdata),
    .raddr_i (slot),
    .rdata_o (var_rdata)
  );

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      item_q        <= '0;
      axis_q        <= AxisX;
      filter_q      <= 1'b0;
      acc_q         <= 1'b0;
      k_q           <= '0;
      rem_q         <= '0;
      den_q         <= '0;
      p_q           <= '0;
      x_q           <= '0;
      diff_q        <= '0;
      prod_q        <= '0;
      est_new_q     <= '0;
      cnt_q         <= '0;
      res_est_q     <= '{default: '0};
      res_var_q     <= '{default: '0};
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      row_valid_q   <= '0;
      proc_noise_q  <= RstProcessNoise;
      meas_noise_q  <= RstMeasureNoise;
      coord_limit_q <= RstCoordLimit;
      init_var_q    <= RstInitVariance;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.data.index)
          CfgProcessNoise: proc_noise_q  <= cfg_i.data.value;
          CfgMeasureNoise: meas_noise_q  <= cfg_i.data.value;
          CfgCoordLimit:   coord_limit_q <= cfg_i.data.value[30:0];
          CfgInitVariance: init_var_q    <= cfg_i.data.value;
          default: ;
        endcase
      end

      // In StDone the output register is reloaded below instead.
      if (out_o.valid && out_o.ready && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            item_q  <= in_i.data;
            axis_q  <= AxisX;
            state_q <= StCheck;
          end
        end
        StCheck: begin
          if (!tag_ok) begin
            acc_q     <= 1'b0;
            res_est_q <= '{default: '0};
            res_var_q <= '{default: '0};
            state_q   <= StDone;
          end else if (item_q.cmd == CmdInit) begin
            acc_q   <= 1'b1;
            state_q <= StInit;
          end else begin
            acc_q    <= in_range;
            filter_q <= in_range;
            state_q  <= StRead;
          end
        end
        StInit: begin
          res_est_q[axis_q] <= coord_sel;
          res_var_q[axis_q] <= init_var_q;
          if (last_axis) begin
            row_valid_q[tag_idx] <= 1'b1;
            state_q              <= StDone;
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          if (!filter_q) begin
            // Rejected: report stored values, write nothing.
            res_est_q[axis_q] <= est_rd;
            res_var_q[axis_q] <= var_rd;
            if (last_axis) begin
              state_q <= StDone;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= StRead;
            end
          end else begin
            x_q     <= est_rd;
            p_q     <= p_new;
            den_q   <= den_new;
            diff_q  <= diff_new;
            rem_q   <= {2'b00, p_new};
            k_q     <= '0;
            cnt_q   <= '0;
            // Zero denominator: gain stays 0.
            state_q <= (den_new == 33'd0) ? StMulGain : StDiv;
          end
        end
        StDiv: begin
          rem_q <= {div_rem[32:0], 1'b0};
          k_q   <= {k_q[15:0], div_ge};
          cnt_q <= cnt_q + DivCntW'(1);
          if (cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= StMulGain;
          end
        end
        StMulGain: begin
          prod_q  <= mul_p;
          state_q <= StMulVar;
        end
        StMulVar: begin
          // Arithmetic shift by 16 floors the correction.
          est_new_q <= x_q + prod_q[47:16];
          prod_q    <= mul_p;
          state_q   <= StWrite;
        end
        StWrite: begin
          res_est_q[axis_q] <= est_new_q;
          res_var_q[axis_q] <= prod_q[47:16];
          if (last_axis) begin
            row_valid_q[tag_idx] <= 1'b1;
            state_q              <= StDone;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= StRead;
          end
        end
        StDone: begin
          if (!out_valid_q || out_o.ready) begin
            out_q.accepted <= acc_q;
            out_q.est_x    <= res_est_q[0];
            out_q.est_y    <= res_est_q[1];
            out_q.est_z    <= res_est_q[2];
            out_q.var_x    <= res_var_q[0];
            out_q.var_y    <= res_var_q[1];
            out_q.var_z    <= res_var_q[2];
            out_valid_q    <= 1'b1;
            state_q        <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `PTKP_ASSERT_IMP(a_write_valid_tag, clk_i, rst_ni, ram_we, tag_ok)
  `PTKP_ASSERT_IMP(a_gain_le_one, clk_i, rst_ni, state_q == StMulGain, k_q <= GainOne)
  `PTKP_ASSERT_IMP(a_var_not_above_prior, clk_i, rst_ni, state_q == StWrite, prod_q[50:48] == 3'b000 && prod_q[47:16] <= p_q)
  `PTKP_ASSERT_NXT(a_accept_starts_check, clk_i, rst_ni, in_i.valid && in_i.ready, state_q == StCheck)
  `PTKP_ASSERT_NXT(a_result_loaded, clk_i, rst_ni, state_q == StDone && (!out_valid_q || out_o.ready), out_valid_q && state_q == StIdle)

endmodule
